// ----- rtl/ppaa_pkg.sv -----
`timescale 1ns / 1ps
// ppaa_pkg: shared types, constants and glyph lookup for the pixel pair ASCII art block.
// No dependencies.
package ppaa_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned CFG_W         = 11;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [1:0] PH_GLYPH = 2'd0;
  localparam logic [1:0] PH_CR    = 2'd1;
  localparam logic [1:0] PH_LF    = 2'd2;

  typedef struct packed {
    logic [7:0] grey_pixel;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       run_last;
  } out_t;

  // Quantized pixel pair handed from the front stage to the emitter
  typedef struct packed {
    logic [1:0] lower;
    logic [1:0] upper;
    logic       eol;
  } pair_t;

  function automatic logic [7:0] glyph(input logic [1:0] lower, input logic [1:0] upper);
    logic [7:0] c;
    unique case ({lower, upper})
      4'h0: c = 8'h40;  // @
      4'h1: c = 8'h56;  // V
      4'h2: c = 8'h59;  // Y
      4'h3: c = 8'h5E;  // ^
      4'h4: c = 8'h67;  // g
      4'h5: c = 8'h24;  // $
      4'h6: c = 8'h54;  // T
      4'h7: c = 8'h22;  // "
      4'h8: c = 8'h67;  // g
      4'h9: c = 8'h6D;  // m
      4'hA: c = 8'h23;  // #
      4'hB: c = 8'h27;  // '
      4'hC: c = 8'h6D;  // m
      4'hD: c = 8'h2C;  // ,
      4'hE: c = 8'h2E;  // .
      4'hF: c = 8'h20;  // space
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ppaa_ram.sv -----
`timescale 1ns / 1ps
// ppaa_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module ppaa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ppaa_front.sv -----
`timescale 1ns / 1ps
// ppaa_front: width register, column/row tracking, line buffer and pair register.
// Depends on ppaa_pkg and ppaa_ram.
module ppaa_front #(
  parameter int unsigned MaxWidth = ppaa_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ppaa_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ppaa_pkg::in_t              in_data_i,
  input  logic                       take_i,
  output logic                       s1_valid_o,
  output ppaa_pkg::pair_t            s1_o
);

  localparam int unsigned AW = $clog2(MaxWidth);
  localparam int unsigned WW = (AW + 1 > ppaa_pkg::CFG_W) ? AW + 1 : ppaa_pkg::CFG_W;

  logic [ppaa_pkg::CFG_W-1:0] width_q;
  logic [AW-1:0]              col_q, col_d, col_cur;
  logic                       odd_q, odd_d, odd_cur;
  logic                       s1_valid_q, s1_valid_d;
  logic [1:0]                 lower_q;
  logic                       eol_q;
  logic [WW-1:0]              w_raw, w_eff;
  logic                       row_end, accept;
  logic [7:0]                 upper_pix;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = s1_valid_q && !take_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    w_raw = WW'(width_q);
    w_eff = w_raw;
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > WW'(MaxWidth)) begin
      w_eff = WW'(MaxWidth);
    end
    col_cur = in_data_i.frame_start ? '0 : col_q;
    odd_cur = in_data_i.frame_start ? 1'b0 : odd_q;
    row_end = (WW'(col_cur) + WW'(1)) >= w_eff;
    col_d   = col_q;
    odd_d   = odd_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        odd_d = !odd_cur;
      end else begin
        col_d = col_cur + AW'(1);
        odd_d = odd_cur;
      end
    end
    if (accept) begin
      s1_valid_d = odd_cur;
    end else if (take_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= ppaa_pkg::WIDTH_RESET;
      col_q      <= '0;
      odd_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        width_q <= cfg_data_i;
      end
      col_q      <= col_d;
      odd_q      <= odd_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && odd_cur) begin
      lower_q <= in_data_i.grey_pixel[7:6];
      eol_q   <= row_end;
    end
  end

  ppaa_ram #(
    .Width(8),
    .Depth(MaxWidth)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (accept && !odd_cur),
    .waddr_i(col_cur),
    .wdata_i(in_data_i.grey_pixel),
    .re_i   (accept && odd_cur),
    .raddr_i(col_cur),
    .rdata_o(upper_pix)
  );

  assign s1_valid_o  = s1_valid_q;
  assign s1_o.lower  = lower_q;
  assign s1_o.upper  = upper_pix[7:6];
  assign s1_o.eol    = eol_q;

  a_odd_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && odd_cur |=> s1_valid_q)
    else $error("odd-row item did not reach pair register");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && row_end |=> col_q == '0)
    else $error("column did not wrap at row end");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    AW'(col_q) == col_q && ({1'b0, col_q} < (AW + 1)'(MaxWidth)))
    else $error("column beyond line buffer");

endmodule

// ----- rtl/ppaa_emit.sv -----
`timescale 1ns / 1ps
// ppaa_emit: glyph lookup and output register that sequences glyph, CR and LF.
// Depends on ppaa_pkg.
module ppaa_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s1_valid_i,
  input  ppaa_pkg::pair_t s1_i,
  output logic            take_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ppaa_pkg::out_t  out_data_o
);

  logic       s2_valid_q, s2_valid_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] char_q, char_d;
  logic       eol_q, eol_d;
  logic       last, out_ok, room;

  assign last   = (phase_q == ppaa_pkg::PH_LF) || (phase_q == ppaa_pkg::PH_GLYPH && !eol_q);
  assign out_ok = s2_valid_q && !out_stall_i;
  assign room   = !s2_valid_q || (out_ok && last);
  assign take_o = room;

  always_comb begin
    s2_valid_d = s2_valid_q;
    phase_d    = phase_q;
    char_d     = char_q;
    eol_d      = eol_q;
    if (s1_valid_i && room) begin
      s2_valid_d = 1'b1;
      phase_d    = ppaa_pkg::PH_GLYPH;
      char_d     = ppaa_pkg::glyph(s1_i.lower, s1_i.upper);
      eol_d      = s1_i.eol;
    end else if (out_ok) begin
      if (last) begin
        s2_valid_d = 1'b0;
      end else if (phase_q == ppaa_pkg::PH_GLYPH) begin
        phase_d = ppaa_pkg::PH_CR;
        char_d  = ppaa_pkg::CHAR_CR;
      end else begin
        phase_d = ppaa_pkg::PH_LF;
        char_d  = ppaa_pkg::CHAR_LF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      phase_q    <= ppaa_pkg::PH_GLYPH;
    end else begin
      s2_valid_q <= s2_valid_d;
      phase_q    <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    eol_q  <= eol_d;
  end

  assign out_valid_o         = s2_valid_q;
  assign out_data_o.text_char = char_q;
  assign out_data_o.run_last  = last;

  a_crlf_only_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && phase_q != ppaa_pkg::PH_GLYPH |-> eol_q)
    else $error("line end characters without row end");

  a_cr_then_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ok && phase_q == ppaa_pkg::PH_CR |=> s2_valid_q && phase_q == ppaa_pkg::PH_LF)
    else $error("CR not followed by LF");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_ok |=> s2_valid_q && $stable(phase_q))
    else $error("pending result lost");

endmodule

// ----- rtl/pixel_pair_ascii_art.sv -----
`timescale 1ns / 1ps
// pixel_pair_ascii_art: one item per cycle while in_stall_o is low; the first result of an odd-row item
// is registered by the line buffer read, then by the output register.
// The last item of an odd row gives three results while the next even-row items flow in; without
// output stall the input stalls only at width 1, once per row pair. Even-row items give no result.
// Async active-low reset clears row/column tracking and pipeline valids, width = 1024;
// line buffer contents are not cleared.
module pixel_pair_ascii_art #(
  parameter int unsigned MaxWidth = ppaa_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ppaa_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ppaa_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ppaa_pkg::out_t             out_data_o
);

  logic            s1_valid;
  ppaa_pkg::pair_t s1_pair;
  logic            take;

  ppaa_front #(
    .MaxWidth(MaxWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .s1_valid_o (s1_valid),
    .s1_o       (s1_pair)
  );

  ppaa_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_i       (s1_pair),
    .take_o     (take),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- tb/tb_pixel_pair_ascii_art.sv -----
`timescale 1ns / 1ps
// tb_pixel_pair_ascii_art: self-checking testbench for the pixel pair ASCII art block.
// Predicts the character items of every accepted pixel and checks each result item in order.
// Depends on ppaa_pkg and rtl/pixel_pair_ascii_art.sv.
module tb_pixel_pair_ascii_art;

  localparam int unsigned LINE_MAX      = ppaa_pkg::MAX_WIDTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS  = 90;
  // glyphs by {lower level, upper level}, first entry in the top byte
  localparam logic [127:0] GLYPHS = "@VY^g$T\"gm#'m,. ";

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [ppaa_pkg::CFG_W-1:0]    cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  ppaa_pkg::in_t                 in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  ppaa_pkg::out_t                out_data_o;

  pixel_pair_ascii_art DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // line buffer model and row tracking
  logic [7:0]                 upper_row [LINE_MAX];
  int unsigned                column;
  bit                         odd_row;
  logic [ppaa_pkg::CFG_W-1:0] width_reg;
  ppaa_pkg::out_t             char_queue [$];

  int unsigned fail_count = 0;
  int unsigned gap_max    = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_left  = 0;

  function automatic logic [7:0] rand_pixel();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void render_pixel(input logic [7:0] pix, input logic start);
    int unsigned w;
    int unsigned col;
    int unsigned idx;
    bit          row_end;
    w = 32'(width_reg);
    if (w == 0) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    if (start) begin
      column  = 0;
      odd_row = 1'b0;
    end
    col     = (column >= LINE_MAX) ? LINE_MAX - 1 : column;
    row_end = (col + 1 >= w);
    if (!odd_row) begin
      upper_row[col] = pix;
    end else begin
      idx = 32'({pix[7:6], upper_row[col][7:6]});
      char_queue.push_back(ppaa_pkg::out_t'{text_char: GLYPHS[127 - 8 * idx -: 8],
                                            run_last: !row_end});
      if (row_end) begin
        char_queue.push_back(ppaa_pkg::out_t'{text_char: ppaa_pkg::CHAR_CR, run_last: 1'b0});
        char_queue.push_back(ppaa_pkg::out_t'{text_char: ppaa_pkg::CHAR_LF, run_last: 1'b1});
      end
    end
    if (row_end) begin
      column  = 0;
      odd_row = !odd_row;
    end else begin
      column = col + 1;
    end
  endfunction

  task automatic send_pixel(input logic [7:0] pix, input logic start);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    in_data_i  = ppaa_pkg::in_t'{grey_pixel: pix, frame_start: start};
    do @(posedge clk_i); while (in_stall_o);
    render_pixel(pix, start);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (char_queue.size() != 0) @(posedge clk_i);
    // even-row items leave no trace in the queue
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [ppaa_pkg::CFG_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    width_reg = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_result
    ppaa_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (char_queue.size() == 0) begin
        $error("unexpected item: text_char %02h run_last %0b",
               out_data_o.text_char, out_data_o.run_last);
        fail_count++;
      end else begin
        want = char_queue.pop_front();
        if (out_data_o.text_char !== want.text_char) begin
          $error("text_char mismatch: expected %02h, actual %02h",
                 want.text_char, out_data_o.text_char);
          fail_count++;
        end
        if (out_data_o.run_last !== want.run_last) begin
          $error("run_last mismatch: expected %0b, actual %0b",
                 want.run_last, out_data_o.run_last);
          fail_count++;
        end
      end
    end
  end

  // all 16 level pairs, pixel values 0 and 255 included
  task automatic test_glyph_table();
    gap_max   = 0;
    stall_pct = 0;
    write_width(11'd16);
    for (int i = 0; i < 16; i++)
      send_pixel({i[1:0], i[2] ? 6'h3F : 6'h00}, i == 0);
    for (int i = 0; i < 16; i++)
      send_pixel({i[3:2], i[0] ? 6'h3F : 6'h00}, 1'b0);
  endtask

  // zero width acts as one, all-ones width keeps the row open
  task automatic test_width_extremes();
    gap_max   = 3;
    stall_pct = 25;
    write_width('0);
    for (int i = 0; i < 6; i++)
      send_pixel(rand_pixel(), i == 0);
    gap_max   = 1;
    stall_pct = 15;
    write_width('1);
    for (int i = 0; i < 12; i++)
      send_pixel(rand_pixel(), i == 0);
  endtask

  task automatic test_mid_row_width();
    gap_max   = 2;
    stall_pct = 30;
    write_width(11'd8);
    for (int i = 0; i < 5; i++)
      send_pixel(rand_pixel(), i == 0);
    // column already past the new width: next pixel ends the even row
    write_width(11'd3);
    send_pixel(rand_pixel(), 1'b0);
    send_pixel(rand_pixel(), 1'b0);
    // shrink inside the odd row
    write_width(11'd1);
    send_pixel(rand_pixel(), 1'b0);
    // grow at the start of an even row
    write_width(11'd4);
    for (int i = 0; i < 8; i++)
      send_pixel(rand_pixel(), 1'b0);
  endtask

  // restart inside an odd row, then a restart after an unpaired even row
  task automatic test_frame_restart();
    gap_max   = 4;
    stall_pct = 40;
    write_width(11'd4);
    for (int i = 0; i < 6; i++)
      send_pixel(rand_pixel(), i == 0);
    for (int i = 0; i < 4; i++)
      send_pixel(rand_pixel(), i == 0);
    for (int i = 0; i < 8; i++)
      send_pixel(rand_pixel(), i == 0);
  endtask

  task automatic test_back_pressure();
    gap_max   = 0;
    stall_pct = 0;
    write_width(11'd3);
    hold_left = 300;
    for (int i = 0; i < 60; i++)
      send_pixel(rand_pixel(), i == 0);
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned rows;
    int unsigned w;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: gap_max = 0;
        1: gap_max = 1;
        2: gap_max = 4;
        default: gap_max = 10;
      endcase
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 40;
        default: stall_pct = 75;
      endcase
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      write_width(w[ppaa_pkg::CFG_W-1:0]);
      rows = $urandom_range(1, 5);
      for (int i = 0; i < rows * w; i++) begin
        // a stray frame start now and then breaks the row sequence
        send_pixel(rand_pixel(), (i == 0) || ($urandom_range(0, 29) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    column      = 0;
    odd_row     = 1'b0;
    width_reg   = ppaa_pkg::WIDTH_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_glyph_table();
    test_width_extremes();
    test_mid_row_width();
    test_frame_restart();
    test_back_pressure();
    test_random_frames();
    wait_idle();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
